/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define CPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/cpsd_pkg.sv */
package cpsd_pkg;

    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_QUEUE_DEPTH     = 4;

    localparam logic [7:0] CODE_END_COLUMN = 8'hFF;

    typedef struct packed {
        logic       action;
        logic       first;
        logic [7:0] data_byte;
        logic [7:0] palette_index;
        logic [7:0] palette_red;
        logic [7:0] palette_green;
        logic [7:0] palette_blue;
    } cpsd_in_t;

    typedef struct packed {
        logic [8:0]  pixel_row;
        logic [15:0] pixel_column;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        inside_res;
    } cpsd_out_t;

    // one queued operation: a palette write or a pixel lookup
    typedef struct packed {
        logic        is_write;
        logic        in_range;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [8:0]  row;
        logic [15:0] column;
        logic        in_bounds;
    } cpsd_op_t;

endpackage

/* rtl/column_post_sprite_decoder_top.sv */
// Column-post sprite decoder. Takes one item per clock while item_stall is low: either
// a sprite stream byte or a palette write. The front parser walks the header, the
// column offsets and the posts at one byte per unstalled cycle and hands palette
// writes and pixel lookups to a short queue (QUEUE_DEPTH entries); the back end
// applies writes and reads the palette RAM through its registered read port, then
// holds each pixel in an output register. Sustained rate is one item per cycle without
// stalls. The palette has no reset or clearing pass: every entry must be written
// before a pixel looks it up.
module column_post_sprite_decoder_top
    import cpsd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  cpsd_in_t  item,
    output logic      pixel_valid,
    input  logic      pixel_stall,
    output cpsd_out_t pixel
);

    logic     full, push, pop, not_empty;
    cpsd_op_t push_op, head;

    cpsd_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .full       (full),
        .push       (push),
        .op         (push_op)
    );

    cpsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    cpsd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .not_empty   (not_empty),
        .head        (head),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule

/* rtl/cpsd_ram.sv */
module cpsd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/cpsd_front.sv */
module cpsd_front
    import cpsd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  cpsd_in_t item,
    input  logic     full,
    output logic     push,
    output cpsd_op_t op
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_TOP,
        PH_LEN,
        PH_PAD1,
        PH_DATA,
        PH_PAD2
    } phase_t;

    localparam logic [8:0] IDX_LIMIT = 9'(PALETTE_ENTRIES);

    phase_t      phase_reg, phase_next;
    logic [2:0]  hc_reg, hc_next;
    logic [7:0]  low_reg, low_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [17:0] skip_reg, skip_next;
    logic [15:0] col_reg, col_next;
    logic [8:0]  row_reg, row_next;
    logic [7:0]  left_reg, left_next;

    phase_t      ph;
    logic [2:0]  hc;
    logic        accept;

    assign item_stall = full;
    assign accept     = item_valid && !full;

    always_comb
    begin
        phase_next  = phase_reg;
        hc_next     = hc_reg;
        low_next    = low_reg;
        width_next  = width_reg;
        height_next = height_reg;
        skip_next   = skip_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        push        = 1'b0;
        op          = '0;
        ph          = item.first ? PH_HEADER : phase_reg;
        hc          = item.first ? 3'd0 : hc_reg;

        if (accept)
        begin
            if (item.action)
            begin
                // writes beyond the store are dropped here
                op.is_write = 1'b1;
                op.in_range = ({1'b0, item.palette_index} < IDX_LIMIT);
                op.index    = item.palette_index;
                op.red      = item.palette_red;
                op.green    = item.palette_green;
                op.blue     = item.palette_blue;
                push        = op.in_range;
            end
            else
            begin
                if (item.first)
                begin
                    col_next = '0;
                end
                case (ph)
                    PH_SKIP:
                    begin
                        skip_next = skip_reg - 18'd1;
                        if (skip_reg == 18'd1)
                        begin
                            phase_next = PH_TOP;
                        end
                    end
                    PH_TOP:
                    begin
                        if (item.data_byte == CODE_END_COLUMN)
                        begin
                            col_next = col_reg + 16'd1;
                        end
                        else
                        begin
                            row_next   = {1'b0, item.data_byte};
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        left_next  = item.data_byte;
                        phase_next = PH_PAD1;
                    end
                    PH_PAD1:
                    begin
                        phase_next = (left_reg == 8'd0) ? PH_PAD2 : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        push         = 1'b1;
                        op.in_range  = ({1'b0, item.data_byte} < IDX_LIMIT);
                        op.index     = item.data_byte;
                        op.row       = row_reg;
                        op.column    = col_reg;
                        op.in_bounds = ({7'd0, row_reg} < height_reg) && (col_reg < width_reg);
                        row_next     = row_reg + 9'd1;
                        left_next    = left_reg - 8'd1;
                        if (left_reg == 8'd1)
                        begin
                            phase_next = PH_PAD2;
                        end
                    end
                    PH_PAD2:
                    begin
                        phase_next = PH_TOP;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                        case (hc)
                            3'd0, 3'd2: low_next    = item.data_byte;
                            3'd1:       width_next  = {item.data_byte, low_reg};
                            3'd3:       height_next = {item.data_byte, low_reg};
                            default:    ;
                        endcase
                        if (hc == 3'd7)
                        begin
                            hc_next    = 3'd0;
                            skip_next  = {width_reg, 2'b00};
                            col_next   = '0;
                            phase_next = (width_reg == 16'd0) ? PH_TOP : PH_SKIP;
                        end
                        else
                        begin
                            hc_next = hc + 3'd1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hc_reg     <= '0;
            low_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            skip_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            hc_reg     <= hc_next;
            low_reg    <= low_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            skip_reg   <= skip_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
        end
    end

endmodule

/* rtl/cpsd_queue.sv */
module cpsd_queue
    import cpsd_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cpsd_op_t push_op,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output cpsd_op_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cpsd_op_t        slots [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/cpsd_back.sv */
module cpsd_back
    import cpsd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      not_empty,
    input  cpsd_op_t  head,
    output logic      pop,
    output logic      pixel_valid,
    input  logic      pixel_stall,
    output cpsd_out_t pixel
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    // lookup stage, waiting on the palette read
    logic        a_valid_reg, a_valid_next;
    logic [8:0]  a_row_reg;
    logic [15:0] a_col_reg;
    logic        a_inside_reg;
    logic        a_hit_reg;

    logic        o_valid_reg, o_valid_next;
    cpsd_out_t   o_item_reg;

    logic        o_free, a_adv, a_free;
    logic        we, re;
    logic [23:0] rgb;

    assign o_free = !o_valid_reg || !pixel_stall;
    assign a_adv  = a_valid_reg && o_free;
    assign a_free = !a_valid_reg || o_free;
    assign we     = not_empty && head.is_write;
    assign re     = not_empty && !head.is_write && a_free;
    assign pop    = we || re;

    cpsd_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (we),
        .waddr (head.index[AW-1:0]),
        .wdata ({head.red, head.green, head.blue}),
        .re    (re),
        .raddr (head.index[AW-1:0]),
        .rdata (rgb)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (re)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (a_adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (!pixel_stall)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            a_row_reg    <= head.row;
            a_col_reg    <= head.column;
            a_inside_reg <= head.in_bounds;
            a_hit_reg    <= head.in_range;
        end
        if (a_adv)
        begin
            o_item_reg.pixel_row    <= a_row_reg;
            o_item_reg.pixel_column <= a_col_reg;
            o_item_reg.red          <= a_hit_reg ? rgb[23:16] : 8'd0;
            o_item_reg.green        <= a_hit_reg ? rgb[15:8] : 8'd0;
            o_item_reg.blue         <= a_hit_reg ? rgb[7:0] : 8'd0;
            o_item_reg.inside_res   <= a_inside_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign pixel_valid = o_valid_reg;
    assign pixel       = o_item_reg;

endmodule

/* rtl/cpsd_checker.sv */
`include "assert_macros.svh"

module cpsd_checker
    import cpsd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input cpsd_in_t  item,
    input logic      pixel_valid,
    input logic      pixel_stall,
    input cpsd_out_t pixel
);

    logic in_blocked;
    logic out_blocked;

    assign in_blocked  = item_valid && item_stall;
    assign out_blocked = pixel_valid && pixel_stall;

    // a held pixel stays offered and unchanged
    `CPSD_ASSERT_NEXT(a_pixel_hold, clk, rst_n, out_blocked, pixel_valid)
    `CPSD_ASSERT_NEXT(a_pixel_stable, clk, rst_n, out_blocked, $stable(pixel))

    // a held input item stays offered and unchanged
    `CPSD_ASSERT_NEXT(a_item_hold, clk, rst_n, in_blocked, item_valid && $stable(item))

    // top row is never the end marker, so a post cannot reach past this row
    `CPSD_ASSERT_IMPL(a_row_bound, clk, rst_n, pixel_valid, pixel.pixel_row <= 9'd509)

    // the queue only fills when the back end was blocked by a stalled pixel
    `CPSD_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_blocked, $past(out_blocked))

endmodule

bind column_post_sprite_decoder_top cpsd_checker u_checker (.*);

/* test/tb_column_post_sprite_decoder_top.sv */
`timescale 1ns / 100ps

module tb_column_post_sprite_decoder_top;
    import cpsd_pkg::*;

    typedef enum logic [2:0] {
        P_HEADER,
        P_OFFSETS,
        P_TOP,
        P_LENGTH,
        P_PAD_LEAD,
        P_INDEX,
        P_PAD_TRAIL
    } parse_phase_t;

    typedef struct {
        cpsd_in_t  in;
        bit        typed;
        cpsd_out_t px;
    } step_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    cpsd_in_t  item;
    logic      pixel_valid;
    logic      pixel_stall;
    cpsd_out_t pixel;

    // decoder shadow state
    logic [23:0]  pal_rgb [256];
    parse_phase_t phase;
    logic [2:0]   hdr_cnt;
    logic [7:0]   low_latch;
    logic [15:0]  spr_w;
    logic [15:0]  spr_h;
    logic [17:0]  skip_left;
    logic [15:0]  col_cnt;
    logic [8:0]   row_pos;
    logic [7:0]   px_left;

    // palette entries that may be looked up
    bit           written [256];
    logic [7:0]   written_list[$];

    cpsd_out_t    expected_pixels[$];
    int           errors;
    int           pixels_checked;
    int           items_sent;
    int           tx_calm;
    int           rx_calm;
    bit           tx_gaps_on;
    int           rx_hold_reqs;

    column_post_sprite_decoder_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit decode_item(input cpsd_in_t it, output cpsd_out_t px);
        logic [23:0] rgb;
        logic [7:0]  b;
        bit          got;
        got = 1'b0;
        px  = '0;
        b   = it.data_byte;
        if (it.action)
        begin
            pal_rgb[it.palette_index] = {it.palette_red, it.palette_green, it.palette_blue};
        end
        else
        begin
            if (it.first)
            begin
                phase   = P_HEADER;
                hdr_cnt = '0;
                col_cnt = '0;
            end
            case (phase)
                P_OFFSETS:
                begin
                    skip_left = skip_left - 18'd1;
                    if (skip_left == '0)
                        phase = P_TOP;
                end
                P_TOP:
                begin
                    if (b == CODE_END_COLUMN)
                        col_cnt = col_cnt + 16'd1;
                    else
                    begin
                        row_pos = {1'b0, b};
                        phase   = P_LENGTH;
                    end
                end
                P_LENGTH:
                begin
                    px_left = b;
                    phase   = P_PAD_LEAD;
                end
                P_PAD_LEAD:
                    phase = (px_left == '0) ? P_PAD_TRAIL : P_INDEX;
                P_INDEX:
                begin
                    rgb             = pal_rgb[b];
                    px.pixel_row    = row_pos;
                    px.pixel_column = col_cnt;
                    px.red          = rgb[23:16];
                    px.green        = rgb[15:8];
                    px.blue         = rgb[7:0];
                    px.inside_res   = ({7'b0, row_pos} < spr_h) && (col_cnt < spr_w);
                    got             = 1'b1;
                    row_pos         = row_pos + 9'd1;
                    px_left         = px_left - 8'd1;
                    if (px_left == '0)
                        phase = P_PAD_TRAIL;
                end
                P_PAD_TRAIL:
                    phase = P_TOP;
                default:
                begin
                    phase = P_HEADER;
                    case (hdr_cnt)
                        3'd0, 3'd2: low_latch = b;
                        3'd1:       spr_w = {b, low_latch};
                        3'd3:       spr_h = {b, low_latch};
                        default:    ;
                    endcase
                    if (hdr_cnt == 3'd7)
                    begin
                        hdr_cnt   = '0;
                        skip_left = {spr_w, 2'b00};
                        col_cnt   = '0;
                        phase     = (skip_left == '0) ? P_TOP : P_OFFSETS;
                    end
                    else
                        hdr_cnt = hdr_cnt + 3'd1;
                end
            endcase
        end
        return got;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int gap_len(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic cpsd_in_t stream_byte(input bit first, input logic [7:0] b);
        cpsd_in_t it;
        it.action        = 1'b0;
        it.first         = first;
        it.data_byte     = b;
        it.palette_index = 8'($urandom_range(0, 255));
        it.palette_red   = 8'($urandom_range(0, 255));
        it.palette_green = 8'($urandom_range(0, 255));
        it.palette_blue  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic cpsd_in_t palette_write(input logic [7:0] idx, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input bit first);
        cpsd_in_t it;
        it.action        = 1'b1;
        it.first         = first;
        it.data_byte     = 8'($urandom_range(0, 255));
        it.palette_index = idx;
        it.palette_red   = r;
        it.palette_green = g;
        it.palette_blue  = b;
        return it;
    endfunction

    function automatic step_t step(input cpsd_in_t it);
        step_t s;
        s.in    = it;
        s.typed = 1'b0;
        s.px    = '0;
        return s;
    endfunction

    function automatic step_t step_px(input cpsd_in_t it, input cpsd_out_t px);
        step_t s;
        s.in    = it;
        s.typed = 1'b1;
        s.px    = px;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= 50)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_pixel(input cpsd_out_t got);
        cpsd_out_t want;
        if (expected_pixels.size() == 0)
            report_mismatch("pixel with none pending, column", got.pixel_column, 0);
        else
        begin
            want = expected_pixels.pop_front();
            pixels_checked++;
            if (got.pixel_row != want.pixel_row)
                report_mismatch("pixel_row", got.pixel_row, want.pixel_row);
            if (got.pixel_column != want.pixel_column)
                report_mismatch("pixel_column", got.pixel_column, want.pixel_column);
            if (got.red != want.red)
                report_mismatch("red", got.red, want.red);
            if (got.green != want.green)
                report_mismatch("green", got.green, want.green);
            if (got.blue != want.blue)
                report_mismatch("blue", got.blue, want.blue);
            if (got.inside_res != want.inside_res)
                report_mismatch("inside_res", got.inside_res, want.inside_res);
        end
    endtask

    task automatic send_item(input cpsd_in_t it, input bit typed, input cpsd_out_t typed_px);
        cpsd_out_t px;
        int        gap;
        // an index byte must look up an entry that was written
        if (!it.action && !it.first && phase == P_INDEX && !written[it.data_byte])
            it.data_byte = written_list[$urandom_range(0, written_list.size() - 1)];
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (decode_item(it, px))
            expected_pixels.push_back(typed ? typed_px : px);
        if (it.action && !written[it.palette_index])
        begin
            written[it.palette_index] = 1'b1;
            written_list.push_back(it.palette_index);
        end
        items_sent++;
        gap = tx_gaps_on ? gap_len(tx_calm) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_byte(input bit first, input logic [7:0] b);
        send_item(stream_byte(first, b), 1'b0, '0);
    endtask

    task automatic maybe_palette_write();
        if ($urandom_range(0, 9) == 0)
            send_item(palette_write(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1))), 1'b0, '0);
    endtask

    task automatic send_header(input logic [15:0] w, input logic [15:0] h);
        send_byte(1'b1, w[7:0]);
        send_byte(1'b0, w[15:8]);
        send_byte(1'b0, h[7:0]);
        send_byte(1'b0, h[15:8]);
        repeat (4) send_byte(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_offsets(input int n);
        repeat (n) send_byte(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_post(input logic [7:0] top, input logic [7:0] len);
        send_byte(1'b0, top);
        maybe_palette_write();
        send_byte(1'b0, len);
        send_byte(1'b0, 8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++)
        begin
            maybe_palette_write();
            send_byte(1'b0, 8'($urandom_range(0, 255)));
        end
        send_byte(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_sprite();
        int r;
        int w;
        int h;
        int len;
        r = $urandom_range(0, 99);
        if (r < 70)
            w = $urandom_range(0, 4);
        else if (r < 85)
            w = $urandom_range(5, 12);
        else
            w = $urandom_range(0, 65535);
        h = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
        send_header(w[15:0], h[15:0]);
        // wide sprite: give up partway through the offsets, next header restarts
        if (w > 12)
        begin
            send_offsets($urandom_range(1, 6));
            return;
        end
        send_offsets(4 * w);
        repeat ($urandom_range(1, w + 2))
        begin
            repeat ($urandom_range(0, 2))
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    len = 0;
                else if (r < 75)
                    len = $urandom_range(1, 6);
                else if (r < 97)
                    len = $urandom_range(7, 30);
                else
                    len = $urandom_range(31, 60);
                send_post(8'($urandom_range(0, 254)), len[7:0]);
            end
            send_byte(1'b0, CODE_END_COLUMN);
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 5))
        begin
            if ($urandom_range(0, 9) < 4)
                maybe_palette_write();
            else
                send_byte($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
        end
    endtask

    // stop offering, then wait for every expected pixel
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall gaps plus one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left  = 0;
        hold_left   = 0;
        hold_seen   = 0;
        pixel_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pixel_valid && !pixel_stall)
                check_pixel(pixel);
            if (rx_hold_reqs != hold_seen)
            begin
                hold_seen = rx_hold_reqs;
                hold_left = 64;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixel_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pixel_stall <= 1'b1;
            end
            else
            begin
                pixel_stall <= 1'b0;
                stall_left = gap_len(rx_calm);
            end
        end
    end

    initial
    begin : main
        step_t plan[$];
        int    random_sent;
        bit    pressure_done;

        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        errors         = 0;
        pixels_checked = 0;
        items_sent     = 0;
        tx_calm        = 0;
        rx_calm        = 0;
        tx_gaps_on     = 1'b1;
        rx_hold_reqs   = 0;
        pressure_done  = 1'b0;

        phase     = P_HEADER;
        hdr_cnt   = '0;
        low_latch = '0;
        spr_w     = '0;
        spr_h     = '0;
        skip_left = '0;
        col_cnt   = '0;
        row_pos   = '0;
        px_left   = '0;
        for (int i = 0; i < 256; i++)
        begin
            pal_rgb[i] = '0;
            written[i] = 1'b0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first flag on a palette write has no effect
        plan.push_back(step(palette_write(8'h00, 8'h00, 8'h00, 8'h00, 1'b1)));
        plan.push_back(step(palette_write(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0)));
        plan.push_back(step(palette_write(8'hA5, 8'h12, 8'h34, 8'h56, 1'b0)));
        // width 1, height 0x00ff, origin words at extremes
        plan.push_back(step(stream_byte(1'b1, 8'h01)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step(stream_byte(1'b0, 8'hFF)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step(stream_byte(1'b0, 8'hFF)));
        plan.push_back(step(stream_byte(1'b0, 8'hFF)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        // offsets: 0xff here does not close a column
        plan.push_back(step(stream_byte(1'b0, 8'hFF)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step(stream_byte(1'b0, 8'hFF)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        // post at row 0xfe with two pixels, the second on row 0xff, outside the height
        plan.push_back(step(stream_byte(1'b0, 8'hFE)));
        plan.push_back(step(stream_byte(1'b0, 8'h02)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step_px(stream_byte(1'b0, 8'hFF),
                               cpsd_out_t'{9'h0FE, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 1'b1}));
        plan.push_back(step_px(stream_byte(1'b0, 8'h00),
                               cpsd_out_t'{9'h0FF, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0}));
        plan.push_back(step(stream_byte(1'b0, 8'hFF)));
        plan.push_back(step(stream_byte(1'b0, CODE_END_COLUMN)));
        // zero length post
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step(stream_byte(1'b0, 8'h00)));
        plan.push_back(step(stream_byte(1'b0, 8'h55)));
        plan.push_back(step(stream_byte(1'b0, 8'hAA)));

        foreach (plan[i])
            send_item(plan[i].in, plan[i].typed, plan[i].px);
        wait_drained();

        random_sent = items_sent;
        while (items_sent - random_sent < 330)
        begin
            if (!pressure_done && items_sent - random_sent > 150)
            begin
                // output held off while a long post keeps coming
                pressure_done = 1'b1;
                send_header(16'h0002, 16'h0180);
                send_offsets(8);
                rx_hold_reqs++;
                send_post(8'hFE, 8'h40);
                send_byte(1'b0, CODE_END_COLUMN);
                wait_drained();
            end
            if ($urandom_range(0, 99) < 85)
                send_sprite();
            else
                send_noise();
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("sent %0d items, checked %0d pixels", items_sent, pixels_checked);
        $display("covered headers, offset skips, short and long posts, palette writes, stalls");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
